/* rtl/core/glru_pkg.sv */
// Shared types and constants for the glyph slot LRU cache.
package glru_pkg;

   localparam int CODE_W   = 21;
   localparam int COORD_W  = 12;
   localparam int IDX_W    = 8;
   localparam int LIMIT_W  = 9;
   localparam int HEIGHT_W = 8;
   localparam int MARGIN_W = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [COORD_W-1:0] COORD_MAX = 12'd4095;

   localparam logic [LIMIT_W-1:0]  RST_SLOT_LIMIT  = 9'd256;
   localparam logic [HEIGHT_W-1:0] RST_FONT_HEIGHT = 8'd16;
   localparam logic [COORD_W-1:0]  RST_ATLAS_WIDTH = 12'd512;
   localparam logic [MARGIN_W-1:0] RST_CELL_GAP    = 4'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_GAP    = 2'd3;

   typedef struct packed {
      logic [CODE_W-1:0] glyph_code;
      logic              glyph_known;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               missing;
      logic [IDX_W-1:0]   slot_index;
      logic [COORD_W-1:0] atlas_x;
      logic [COORD_W-1:0] atlas_y;
      logic               draw_needed;
      logic               evicted;
      logic [CODE_W-1:0]  evicted_code;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [COORD_W-1:0]   data;
   } csr_type;

endpackage

/* rtl/core/glru_if.sv */
// Valid/ready channel interfaces for the glyph slot LRU cache.
interface glru_req_if;
   logic                  valid;
   logic                  ready;
   glru_pkg::req_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface glru_rsp_if;
   logic                  valid;
   logic                  ready;
   glru_pkg::rsp_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface glru_csr_if;
   logic                  valid;
   logic                  ready;
   glru_pkg::csr_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/glru_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
module glru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/core/glyph_slot_lru_cache.sv */
// Top level of the glyph slot LRU cache: lookup scan, list update and atlas cursor.
//
// Channels: req (glyph_code, glyph_known) in, rsp (one result per request) out,
// csr (index, data) writes slot_limit, font_height, atlas_width, cell_gap.
// All channels are valid/ready; a transfer happens when both are high.
// A request is handled one at a time. An unknown glyph's result is valid the
// cycle after the request is taken.
// A known glyph scans the code RAM one slot per cycle over the used slots,
// then updates the list, reads the atlas position and registers the result;
// the scan length set by the one read port of the code RAM dominates.
// The result sits in an output register; a stalled receiver holds it and
// the next request waits until it is taken.
// Reset (synchronous, active high) empties the list, clears the cursor and
// restores the register defaults; the slot RAMs are not cleared, since no
// entry that was never written reaches a result.
module glyph_slot_lru_cache #(
   parameter int SLOTS = 256
) (
   input  logic   clock,
   input  logic   reset,
   glru_req_if.sink   req,
   glru_rsp_if.source rsp,
   glru_csr_if.sink   csr
);
   import glru_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_SCAN   = 11'b00000000010,
      ST_CHECK  = 11'b00000000100,
      ST_RDOLD  = 11'b00000001000,
      ST_RDNEW  = 11'b00000010000,
      ST_WOLD   = 11'b00000100000,
      ST_WNEW   = 11'b00001000000,
      ST_APP    = 11'b00010000000,
      ST_APP2   = 11'b00100000000,
      ST_RDXY   = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0]  slot_limit_ff;
   logic [HEIGHT_W-1:0] font_height_ff;
   logic [COORD_W-1:0]  atlas_width_ff;
   logic [MARGIN_W-1:0] cell_gap_ff;

   logic [AW-1:0]      oldest_ff, oldest_in, newest_ff, newest_in;
   logic [CW-1:0]      used_ff, used_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;

   logic [CODE_W-1:0]  code_ff, code_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic               hit_ff, hit_in, evict_ff, evict_in, fresh_ff, fresh_in;
   logic               empty_ff, empty_in;
   logic [CODE_W-1:0]  old_code_ff, old_code_in;
   logic [AW-1:0]      lo_ff, lo_in, ln_ff, ln_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               code_we;
   logic [AW-1:0]      code_wa, code_ra;
   logic [CODE_W-1:0]  code_wd, code_rd;
   logic               xy_we;
   logic [AW-1:0]      xy_wa, xy_ra;
   logic [2*COORD_W-1:0] xy_wd, xy_rd;
   logic               old_we, new_we;
   logic [AW-1:0]      old_wa, new_wa, old_wd, new_wd, link_ra;
   logic [AW-1:0]      old_rd, new_rd;

   glru_ram #(.WIDTH(CODE_W), .DEPTH(SLOTS)) u_code (
      .clock, .wr_en(code_we), .wr_addr(code_wa), .wr_data(code_wd),
      .rd_addr(code_ra), .rd_data(code_rd));
   glru_ram #(.WIDTH(2*COORD_W), .DEPTH(SLOTS)) u_xy (
      .clock, .wr_en(xy_we), .wr_addr(xy_wa), .wr_data(xy_wd),
      .rd_addr(xy_ra), .rd_data(xy_rd));
   glru_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_older (
      .clock, .wr_en(old_we), .wr_addr(old_wa), .wr_data(old_wd),
      .rd_addr(link_ra), .rd_data(old_rd));
   glru_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_newer (
      .clock, .wr_en(new_we), .wr_addr(new_wa), .wr_data(new_wd),
      .rd_addr(link_ra), .rd_data(new_rd));

   logic [CW-1:0] limit;
   logic [CW:0]   lim_w;
   logic [COORD_W:0] fit_sum, adv_sum, y_sum, step;
   logic [COORD_W-1:0] new_x, new_y;
   logic          scan_prev_ok;

   assign req.ready = state_ff == ST_IDLE && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      lim_w = (CW+1)'(slot_limit_ff);
      if (lim_w == '0) lim_w = (CW+1)'(1);
      if (lim_w > (CW+1)'(SLOTS)) lim_w = (CW+1)'(SLOTS);
      limit = lim_w[CW-1:0];
   end

   always_comb begin
      fit_sum = {1'b0, cur_x_ff} + (COORD_W+1)'(font_height_ff);
      if (fit_sum > {1'b0, atlas_width_ff}) begin
         new_x = COORD_W'(cell_gap_ff);
         y_sum = {1'b0, cur_y_ff} + (COORD_W+1)'(font_height_ff);
         new_y = y_sum > (COORD_W+1)'(COORD_MAX) ? COORD_MAX : y_sum[COORD_W-1:0];
      end else begin
         new_x = cur_x_ff;
         y_sum = '0;
         new_y = cur_y_ff;
      end
      step = (COORD_W+1)'(font_height_ff) + (COORD_W+1)'(cell_gap_ff);
      adv_sum = {1'b0, new_x} + step;
   end

   always_comb begin
      state_in = state_ff;
      oldest_in = oldest_ff; newest_in = newest_ff; used_in = used_ff;
      cur_x_in = cur_x_ff; cur_y_in = cur_y_ff;
      code_in = code_ff; scan_in = scan_ff; slot_in = slot_ff;
      hit_in = hit_ff; evict_in = evict_ff; fresh_in = fresh_ff; empty_in = empty_ff;
      old_code_in = old_code_ff; lo_in = lo_ff; ln_in = ln_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      code_we = 1'b0; code_wa = slot_ff; code_wd = code_ff;
      code_ra = scan_ff[AW-1:0];
      xy_we = 1'b0; xy_wa = slot_ff; xy_wd = {new_x, new_y}; xy_ra = slot_ff;
      old_we = 1'b0; old_wa = slot_ff; old_wd = newest_ff;
      new_we = 1'b0; new_wa = newest_ff; new_wd = slot_ff;
      link_ra = slot_ff;
      scan_prev_ok = 1'b0;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               code_in = req.payload.glyph_code;
               scan_in = '0;
               hit_in = 1'b0; evict_in = 1'b0; fresh_in = 1'b0;
               old_code_in = '0;
               code_ra = '0;
               if (!req.payload.glyph_known) begin
                  rsp_in = '0;
                  rsp_in.missing = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // code_rd holds entry scan_ff-1 when scan_ff > 0
            scan_prev_ok = scan_ff != '0;
            if (scan_prev_ok && code_rd == code_ff) begin
               slot_in = AW'(scan_ff - CW'(1));
               hit_in = 1'b1;
               state_in = ST_CHECK;
            end else if (scan_ff >= used_ff) begin
               state_in = ST_CHECK;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
            if (state_in == ST_CHECK && !hit_in) begin
               if (used_ff >= limit) begin
                  evict_in = 1'b1;
                  slot_in = oldest_ff;
               end else begin
                  fresh_in = 1'b1;
                  slot_in = used_ff[AW-1:0];
               end
            end
            code_ra = state_in == ST_CHECK ? slot_in : code_ra;
            link_ra = slot_in;
         end
         ST_CHECK: begin
            // code_rd = slot_code[slot], link reads valid
            old_code_in = evict_ff ? code_rd : '0;
            empty_in = evict_ff ? used_ff <= CW'(1) : used_ff == '0;
            lo_in = old_rd; ln_in = new_rd;
            if (fresh_ff) begin
               state_in = ST_APP;
            end else if (hit_ff && slot_ff == newest_ff) begin
               state_in = ST_RDXY;
            end else begin
               state_in = ST_WOLD;
            end
         end
         ST_WOLD: begin
            // unlink slot
            if (slot_ff == oldest_ff) begin
               oldest_in = ln_ff;
            end else begin
               new_we = 1'b1; new_wa = lo_ff; new_wd = ln_ff;
            end
            if (slot_ff == newest_ff) begin
               newest_in = lo_ff;
            end else begin
               old_we = 1'b1; old_wa = ln_ff; old_wd = lo_ff;
            end
            state_in = ST_APP;
         end
         ST_APP: begin
            if (empty_ff) begin
               oldest_in = slot_ff;
            end else begin
               new_we = 1'b1; new_wa = newest_ff; new_wd = slot_ff;
               old_we = 1'b1; old_wa = slot_ff; old_wd = newest_ff;
            end
            newest_in = slot_ff;
            if (!hit_ff) begin
               code_we = 1'b1;
            end
            if (fresh_ff) begin
               used_in = used_ff + CW'(1);
               xy_we = 1'b1;
               cur_x_in = new_x; cur_y_in = new_y;
               cur_x_in = adv_sum > (COORD_W+1)'(COORD_MAX) ? COORD_MAX
                                                             : adv_sum[COORD_W-1:0];
            end
            state_in = ST_APP2;
         end
         ST_APP2: begin
            state_in = ST_RDXY;
         end
         ST_RDXY: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_in = '0;
            rsp_in.hit = hit_ff;
            rsp_in.slot_index = IDX_W'(slot_ff);
            rsp_in.atlas_x = xy_rd[2*COORD_W-1:COORD_W];
            rsp_in.atlas_y = xy_rd[COORD_W-1:0];
            rsp_in.draw_needed = !hit_ff;
            rsp_in.evicted = evict_ff;
            rsp_in.evicted_code = old_code_ff;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         oldest_ff <= '0; newest_ff <= '0; used_ff <= '0;
         cur_x_ff <= '0; cur_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
         slot_limit_ff <= RST_SLOT_LIMIT;
         font_height_ff <= RST_FONT_HEIGHT;
         atlas_width_ff <= RST_ATLAS_WIDTH;
         cell_gap_ff <= RST_CELL_GAP;
      end else begin
         state_ff <= state_in;
         oldest_ff <= oldest_in; newest_ff <= newest_in; used_ff <= used_in;
         cur_x_ff <= cur_x_in; cur_y_ff <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            case (csr.payload.index)
               CSR_SLOT_LIMIT:  slot_limit_ff  <= csr.payload.data[LIMIT_W-1:0];
               CSR_FONT_HEIGHT: font_height_ff <= csr.payload.data[HEIGHT_W-1:0];
               CSR_ATLAS_WIDTH: atlas_width_ff <= csr.payload.data;
               CSR_CELL_GAP:    cell_gap_ff    <= csr.payload.data[MARGIN_W-1:0];
               default: ;
            endcase
         end
      end
      code_ff <= code_in; scan_ff <= scan_in; slot_ff <= slot_in;
      hit_ff <= hit_in; evict_ff <= evict_in; fresh_ff <= fresh_in;
      empty_ff <= empty_in; old_code_ff <= old_code_in;
      lo_ff <= lo_in; ln_ff <= ln_in; rsp_ff <= rsp_in;
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(SLOTS)) else $error("used count above slot count");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE) else $error("work while result pending");
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      used_ff != $past(used_ff) |-> used_ff == $past(used_ff) + CW'(1))
      else $error("used count jumped");
   a_miss_draws: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.missing |-> rsp_ff.draw_needed == !rsp_ff.hit)
      else $error("draw flag wrong");
endmodule

/* sim/glru_tb_if.sv */
// Testbench-side helper types shared by the glyph cache testbench.
package glru_tb_pkg;
   import glru_pkg::*;

   class glyph_scoreboard;
      rsp_type pending[$];
      int      mismatches;

      logic [CODE_W-1:0]  code_tab[256];
      logic [COORD_W-1:0] x_tab[256];
      logic [COORD_W-1:0] y_tab[256];
      int                 older[256];
      int                 newer[256];
      int                 oldest, newest, used;
      int                 cur_x, cur_y;
      int                 limit_reg, height_reg, width_reg, margin_reg;

      function new();
         oldest = 0; newest = 0; used = 0; cur_x = 0; cur_y = 0;
         limit_reg = 256; height_reg = 16; width_reg = 512; margin_reg = 1;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
         case (idx)
            CSR_SLOT_LIMIT:  limit_reg  = val[LIMIT_W-1:0];
            CSR_FONT_HEIGHT: height_reg = val[HEIGHT_W-1:0];
            CSR_ATLAS_WIDTH: width_reg  = val;
            CSR_CELL_GAP:    margin_reg = val[MARGIN_W-1:0];
            default: ;
         endcase
      endfunction

      function int sat(int v);
         return (v > 4095) ? 4095 : v;
      endfunction

      function void unlink(int s);
         if (s == oldest) oldest = newer[s];
         else newer[older[s]] = newer[s];
         if (s == newest) newest = older[s];
         else older[newer[s]] = older[s];
      endfunction

      function void append(int s, bit empty);
         if (empty) oldest = s;
         else begin
            newer[newest] = s;
            older[s] = newest;
         end
         newest = s;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int s, lim;
         bit found;
         e = '0;
         found = 0;
         s = 0;
         if (!r.glyph_known) begin
            e.missing = 1'b1;
            pending.push_back(e);
            return;
         end
         for (int i = 0; i < used; i++) begin
            if (code_tab[i] == r.glyph_code) begin
               s = i;
               found = 1;
               break;
            end
         end
         if (found) begin
            if (s != newest) begin
               unlink(s);
               append(s, 0);
            end
            e.hit = 1'b1;
         end else begin
            lim = limit_reg;
            if (lim < 1) lim = 1;
            if (lim > 256) lim = 256;
            if (used >= lim) begin
               s = oldest;
               e.evicted = 1'b1;
               e.evicted_code = code_tab[s];
               unlink(s);
               append(s, used <= 1);
            end else begin
               s = used;
               append(s, used == 0);
               used++;
               if (cur_x + height_reg > width_reg) begin
                  cur_x = margin_reg;
                  cur_y = sat(cur_y + height_reg);
               end
               x_tab[s] = COORD_W'(cur_x);
               y_tab[s] = COORD_W'(cur_y);
               cur_x = sat(cur_x + height_reg + margin_reg);
            end
            code_tab[s] = r.glyph_code;
            e.draw_needed = 1'b1;
         end
         e.slot_index = IDX_W'(s);
         e.atlas_x = x_tab[s];
         e.atlas_y = y_tab[s];
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", a);
            return;
         end
         e = pending.pop_front();
         if (a !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, actual %p", e, a);
         end
      endfunction
   endclass
endpackage

/* sim/glyph_slot_lru_cache_tb.sv */
// Self-checking testbench for the glyph slot LRU cache with a scoreboard class.
module glyph_slot_lru_cache_tb;
   import glru_pkg::*;
   import glru_tb_pkg::*;

   logic clock;
   logic reset;
   glru_req_if req_ch();
   glru_rsp_if rsp_ch();
   glru_csr_if csr_ch();

   glyph_slot_lru_cache u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   glyph_scoreboard board;
   bit   quiet_phase;
   bit   hold_off;
   int   idle_cycles;
   logic [CODE_W-1:0] recent_codes[$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      csr_ch.valid = 0;
      csr_ch.payload = '0;
      rsp_ch.ready = 0;
      reset = 1;
      quiet_phase = 0;
      hold_off = 0;
      board = new();
   end

   // receiver side: random stalls, a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.payload);
         if (hold_off) rsp_ch.ready <= 0;
         else if (!quiet_phase && $urandom_range(0, 5) == 0) rsp_ch.ready <= 0;
         else rsp_ch.ready <= 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(logic [CODE_W-1:0] code, logic known);
      req_type r;
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      r.glyph_code = code;
      r.glyph_known = known;
      req_ch.valid <= 1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(r);
      if (known) begin
         recent_codes.push_back(code);
         if (recent_codes.size() > 40) void'(recent_codes.pop_front());
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      csr_type c;
      c.index = idx;
      c.data = val;
      csr_ch.valid <= 1;
      csr_ch.payload <= c;
      do @(posedge clock); while (!csr_ch.ready);
      board.write_reg(idx, val);
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_ch.valid <= 0;
      while (board.pending.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(int lim, int h, int w, int m);
      drain();
      write_reg(CSR_SLOT_LIMIT, COORD_W'(lim));
      write_reg(CSR_FONT_HEIGHT, COORD_W'(h));
      write_reg(CSR_ATLAS_WIDTH, COORD_W'(w));
      write_reg(CSR_CELL_GAP, COORD_W'(m));
      csr_ch.valid <= 0;
   endtask

   task automatic random_requests(int count, int pool);
      logic [CODE_W-1:0] code;
      for (int i = 0; i < count; i++) begin
         if (recent_codes.size() != 0 && $urandom_range(0, 2) == 0)
            code = recent_codes[$urandom_range(0, recent_codes.size() - 1)];
         else if ($urandom_range(0, 4) == 0)
            code = CODE_W'($urandom_range(0, 2097151));
         else
            code = CODE_W'($urandom_range(0, pool));
         send_request(code, $urandom_range(0, 9) != 0);
      end
   endtask

   initial begin
      @(posedge clock);
      @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, unknown, hit, eviction
      send_request(21'h1FFFFF, 0);
      send_request(21'h000000, 1);
      send_request(21'h1FFFFF, 1);
      send_request(21'h000000, 1);
      send_request(21'h155555, 1);
      send_request(21'h0AAAAA, 1);
      send_request(21'h155555, 1);
      send_request(21'h0AAAAA, 0);
      configure(2, 255, 4095, 15);
      send_request(21'h000042, 1);
      send_request(21'h000043, 1);
      send_request(21'h000044, 1);
      send_request(21'h000043, 1);
      send_request(21'h000045, 1);
      configure(0, 1, 0, 0);
      send_request(21'h000046, 1);
      send_request(21'h000047, 1);

      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_off <= 1;
            repeat (60) @(posedge clock);
            hold_off <= 0;
         end
         random_requests(6, 30);
      join

      configure(256, 16, 512, 1);
      random_requests(200, 300);
      configure(8, 255, 600, 15);
      random_requests(150, 20);
      configure(1, 200, 1, 0);
      random_requests(60, 10);
      configure(511, 255, 4095, 7);
      random_requests(150, 2000);
      configure(4, 37, 100, 3);
      quiet_phase = 1;
      random_requests(200, 12);

      drain();
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
